FILE: rtl/rvq_dequant_matvec_defines.svh
// Assertion macros used by the controller, rvqdm_ctrl.
// Depends on nothing; the asserting modules supply clk_i and rst_ni.
`ifndef RVQ_DEQUANT_MATVEC_DEFINES_SVH
`define RVQ_DEQUANT_MATVEC_DEFINES_SVH
`ifndef SYNTHESIS
`define RVQDM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rvqdm check failed");
`define RVQDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rvqdm check failed");
`define RVQDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rvqdm check failed");
`else
`define RVQDM_ASSERT(lbl, cond)
`define RVQDM_ASSERT_IMP(lbl, ante, cons)
`define RVQDM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rvqdm_pkg.sv
// Shared constants, codes and control/status types of the RVQ dequant matvec.
// Used by the controller, the datapath and the top level.
package rvqdm_pkg;

  localparam int unsigned CODES      = 256;
  localparam int unsigned MAX_IN     = 1024;
  localparam int unsigned MAX_GROUP  = 8;
  localparam int unsigned MAX_STAGES = 3;
  localparam int unsigned MAX_COLS   = 4;

  localparam int unsigned POS_W = 14;
  localparam int unsigned CB_AW = 13;
  localparam int unsigned ACT_AW = 12;

  localparam logic [1:0] OP_LOAD_CB  = 2'd0;
  localparam logic [1:0] OP_LOAD_ACT = 2'd1;
  localparam logic [1:0] OP_GROUP    = 2'd2;

  localparam logic [1:0] CFG_GROUP_SIZE   = 2'd0;
  localparam logic [1:0] CFG_STAGE_COUNT  = 2'd1;
  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd2;

  // Float operation requested of the datapath
  typedef enum logic [2:0] {
    FOP_NONE,
    FOP_WADD,
    FOP_SCALE,
    FOP_MUL,
    FOP_ACC
  } fop_e;

  typedef struct packed {
    logic       cb_rd;
    logic       act_rd;
    fop_e       fop;
    logic       w_clr;
    logic       emit;
    logic       last;
    logic       sum_clr;
    logic [1:0] st;
    logic [2:0] e;
    logic [1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] g;
    logic [1:0] s;
    logic [2:0] n;
    logic       pos_ok;
    logic       row_end;
    logic       fp_done;
  } dp_stat_t;

endpackage

FILE: rtl/rvqdm_fpu.sv
// Two-stage IEEE binary32 add / multiply unit, round to nearest even.
// Stage one aligns and adds or multiplies, stage two normalises and rounds.
module rvqdm_fpu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        mul_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  localparam logic [31:0] QNAN_DEF = 32'hFFC00000;
  localparam logic [31:0] QBIT     = 32'h00400000;

  logic               s1_valid_q;
  logic               s1_spec_q, s1_spec_d;
  logic [31:0]        s1_sval_q, s1_sval_d;
  logic               s1_sign_q, s1_sign_d;
  logic signed [10:0] s1_exp_q, s1_exp_d;
  logic [49:0]        s1_mant_q, s1_mant_d;
  logic               done_q;
  logic [31:0]        res_q, res_d;

  // Stage one: classify, then align-add or multiply
  always_comb begin
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
    logic [7:0]  ea, eb, el, es, d;
    logic [23:0] ma, mb;
    logic [49:0] ml, ms, sh;
    logic        sticky, sl, ss;
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    s1_spec_d = 1'b0;
    s1_sval_d = 32'd0;
    s1_sign_d = 1'b0;
    s1_exp_d  = 11'sd0;
    s1_mant_d = 50'd0;
    swap = (b_i[30:0] > a_i[30:0]);
    el = swap ? eb : ea;
    es = swap ? ea : eb;
    sl = swap ? b_i[31] : a_i[31];
    ss = swap ? a_i[31] : b_i[31];
    ml = {1'b0, (swap ? mb : ma), 25'd0};
    ms = {1'b0, (swap ? ma : mb), 25'd0};
    d  = el - es;
    if (d > 8'd49) begin
      sh = 50'd0;
      sticky = (ms != 50'd0);
    end else begin
      sh = ms >> d[5:0];
      sticky = ((ms & ~({50{1'b1}} << d[5:0])) != 50'd0);
    end
    if (a_nan) begin
      s1_spec_d = 1'b1;
      s1_sval_d = a_i | QBIT;
    end else if (b_nan) begin
      s1_spec_d = 1'b1;
      s1_sval_d = b_i | QBIT;
    end else if (mul_i) begin
      if ((a_inf && b_zero) || (b_inf && a_zero)) begin
        s1_spec_d = 1'b1;
        s1_sval_d = QNAN_DEF;
      end else if (a_inf || b_inf) begin
        s1_spec_d = 1'b1;
        s1_sval_d = {a_i[31] ^ b_i[31], 8'hFF, 23'd0};
      end else begin
        s1_sign_d = a_i[31] ^ b_i[31];
        s1_exp_d  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd125;
        s1_mant_d = {2'b00, 48'(ma) * 48'(mb)};
      end
    end else begin
      if (a_inf && b_inf && (a_i[31] != b_i[31])) begin
        s1_spec_d = 1'b1;
        s1_sval_d = QNAN_DEF;
      end else if (a_inf) begin
        s1_spec_d = 1'b1;
        s1_sval_d = a_i;
      end else if (b_inf) begin
        s1_spec_d = 1'b1;
        s1_sval_d = b_i;
      end else begin
        s1_exp_d = $signed({3'b000, el});
        if (sl == ss) begin
          s1_mant_d = ml + (sh | {49'd0, sticky});
          s1_sign_d = sl;
        end else begin
          s1_mant_d = ml - (sh | {49'd0, sticky});
          // exact cancellation rounds to plus zero
          s1_sign_d = (s1_mant_d == 50'd0) ? 1'b0 : sl;
        end
      end
    end
  end

  // Stage two: normalise, denormalise on underflow, round, pack
  always_comb begin
    logic [5:0]         p, rsh;
    logic signed [11:0] e, rs;
    logic [49:0]        m;
    logic               subn, sticky, g, stk;
    logic [23:0]        keep;
    logic [24:0]        r;
    p = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (s1_mant_q[i]) p = 6'(i);
    end
    m = s1_mant_q << (6'd49 - p);
    e = {s1_exp_q[10], s1_exp_q} + 12'($signed({1'b0, p})) - 12'sd48;
    subn = 1'b0;
    sticky = 1'b0;
    rs = 12'sd1 - e;
    rsh = rs[5:0];
    if (e < 12'sd1) begin
      subn = 1'b1;
      if (rs > 12'sd49) begin
        sticky = (m != 50'd0);
        m = 50'd0;
      end else begin
        sticky = ((m & ~({50{1'b1}} << rsh)) != 50'd0);
        m = m >> rsh;
      end
      m[0] = m[0] | sticky;
    end
    keep = m[49:26];
    g    = m[25];
    stk  = (m[24:0] != 25'd0);
    r    = {1'b0, keep} + {24'd0, g & (stk | keep[0])};
    if (s1_spec_q) begin
      res_d = s1_sval_q;
    end else if (s1_mant_q == 50'd0) begin
      res_d = {s1_sign_q, 31'd0};
    end else if (subn) begin
      res_d = {s1_sign_q, 7'd0, r[23], r[22:0]};
    end else begin
      if (r[24]) begin
        e = e + 12'sd1;
        r = r >> 1;
      end
      if (e >= 12'sd255) res_d = {s1_sign_q, 8'hFF, 23'd0};
      else res_d = {s1_sign_q, e[7:0], r[22:0]};
    end
  end

  // Advance the two-stage pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_spec_q <= s1_spec_d;
    s1_sval_q <= s1_sval_d;
    s1_sign_q <= s1_sign_d;
    s1_exp_q  <= s1_exp_d;
    s1_mant_q <= s1_mant_d;
    res_q     <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/rvqdm_datapath.sv
// Datapath: configuration, codebook and activation memories, working registers,
// column sums and result registers. Uses rvqdm_pkg and rvqdm_fpu.
module rvqdm_datapath
  import rvqdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  stage_i,
  input  logic [9:0]  index_i,
  input  logic [2:0]  sub_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  code0_i,
  input  logic [7:0]  code1_i,
  input  logic [7:0]  code2_i,
  input  logic [15:0] scale_i,
  input  logic [11:0] row_i,
  input  logic        row_end_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic        strobe_o,
  output logic [11:0] out_row_o,
  output logic [1:0]  out_column_o,
  output logic [31:0] sum_value_o,
  output logic        last_o
);

  logic [15:0] cb_mem [MAX_STAGES * CODES * MAX_GROUP];
  logic [31:0] act_mem [MAX_COLS * MAX_IN];

  logic [3:0]  grp_q;
  logic [1:0]  stg_q;
  logic [2:0]  col_q;
  logic [3:0]  g_sat;
  logic [2:0]  n_sat;

  logic [7:0]  code_q [MAX_STAGES];
  logic [15:0] scale_q;
  logic [11:0] row_q;
  logic        row_end_q;
  logic [12:0] base_q;
  logic [POS_W-1:0] pos;

  logic [15:0] cb_rdata_q;
  logic [31:0] act_rdata_q;
  logic [31:0] w_q, sw_q, prod_q;
  logic [31:0] sums_q [MAX_COLS];
  logic [31:0] sum_sel;
  fop_e        dest_q;
  logic [1:0]  dcol_q;

  logic        fp_start, fp_mul, fp_done;
  logic [31:0] fp_a, fp_b, fp_res;

  logic        strobe_q;
  logic [11:0] out_row_q;
  logic [1:0]  out_col_q;
  logic [31:0] sum_q;
  logic        last_q;

  // Widen an fp16 pattern to fp32
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] k;
    logic [9:0] mn;
    logic [7:0] eo;
    ex = h[14:10];
    man = h[9:0];
    k = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) k = 4'(i);
    end
    mn = man << (4'd10 - k);
    eo = 8'd103 + {4'd0, k};
    if (ex == 5'h1F) half_to_single = {h[15], 8'hFF, man, 13'd0};
    else if (ex != 5'd0) half_to_single = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    else if (man == 10'd0) half_to_single = {h[15], 31'd0};
    else half_to_single = {h[15], eo, mn, 13'd0};
  endfunction

  // Saturate the configuration
  assign g_sat = (grp_q > 4'(MAX_GROUP)) ? 4'(MAX_GROUP) : grp_q;
  assign n_sat = (col_q > 3'(MAX_COLS)) ? 3'(MAX_COLS) : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= 4'd8;
      stg_q <= 2'd1;
      col_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROUP_SIZE:   grp_q <= cfg_data_i;
        CFG_STAGE_COUNT:  stg_q <= cfg_data_i[1:0];
        CFG_COLUMN_COUNT: col_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Write loads into the stores, capture group beats
  always_ff @(posedge clk_i) begin
    if (accept_i && (opcode_i == OP_LOAD_CB) && (stage_i < 2'(MAX_STAGES))
        && (index_i[9:8] == 2'd0)) begin
      cb_mem[{stage_i, index_i[7:0], sub_i}] <= value_i[15:0];
    end
    if (accept_i && (opcode_i == OP_LOAD_ACT) && !sub_i[2]) begin
      act_mem[{sub_i[1:0], index_i}] <= value_i;
    end
    if (accept_i && (opcode_i == OP_GROUP)) begin
      code_q[0] <= code0_i;
      code_q[1] <= code1_i;
      code_q[2] <= code2_i;
      scale_q   <= scale_i;
      row_q     <= row_i;
      row_end_q <= row_end_i;
      base_q    <= 13'(index_i) * 13'(g_sat);
    end
    if (cmd_i.cb_rd) cb_rdata_q <= cb_mem[{cmd_i.st, code_q[cmd_i.st], cmd_i.e}];
    if (cmd_i.act_rd) act_rdata_q <= act_mem[{cmd_i.col, pos[9:0]}];
  end

  assign pos = {1'b0, base_q} + {11'd0, cmd_i.e};
  assign sum_sel = sums_q[cmd_i.col];

  // Select float operands
  always_comb begin
    fp_start = (cmd_i.fop != FOP_NONE);
    fp_mul = 1'b0;
    fp_a = w_q;
    fp_b = half_to_single(cb_rdata_q);
    case (cmd_i.fop)
      FOP_SCALE: begin
        fp_mul = 1'b1;
        fp_a = half_to_single(scale_q);
        fp_b = w_q;
      end
      FOP_MUL: begin
        fp_mul = 1'b1;
        fp_a = sw_q;
        fp_b = act_rdata_q;
      end
      FOP_ACC: begin
        fp_a = sum_sel;
        fp_b = prod_q;
      end
      default: ;
    endcase
  end

  rvqdm_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fp_start),
    .mul_i   (fp_mul),
    .a_i     (fp_a),
    .b_i     (fp_b),
    .done_o  (fp_done),
    .res_o   (fp_res)
  );

  // Hold the destination of the operation in flight
  always_ff @(posedge clk_i) begin
    if (fp_start) begin
      dest_q <= cmd_i.fop;
      dcol_q <= cmd_i.col;
    end
    if (cmd_i.w_clr) w_q <= 32'd0;
    if (fp_done) begin
      case (dest_q)
        FOP_WADD:  w_q <= fp_res;
        FOP_SCALE: sw_q <= fp_res;
        FOP_MUL:   prod_q <= fp_res;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      out_row_q <= row_q;
      out_col_q <= cmd_i.col;
      sum_q     <= sum_sel;
      last_q    <= cmd_i.last;
    end
  end

  // Accumulate column sums, clear at row end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_COLS; i++) sums_q[i] <= 32'd0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cmd_i.sum_clr) begin
        for (int i = 0; i < MAX_COLS; i++) sums_q[i] <= 32'd0;
      end else if (fp_done && (dest_q == FOP_ACC)) begin
        sums_q[dcol_q] <= fp_res;
      end
    end
  end

  assign stat_o.g       = g_sat;
  assign stat_o.s       = stg_q;
  assign stat_o.n       = n_sat;
  assign stat_o.pos_ok  = (pos < POS_W'(MAX_IN));
  assign stat_o.row_end = row_end_q;
  assign stat_o.fp_done = fp_done;

  assign strobe_o     = strobe_q;
  assign out_row_o    = out_row_q;
  assign out_column_o = out_col_q;
  assign sum_value_o  = sum_q;
  assign last_o       = last_q;

endmodule

FILE: rtl/rvqdm_ctrl.sv
// Controller: sequences elements, stages and columns of a group beat.
// Uses rvqdm_pkg types and the assertion macros header.
`include "rvq_dequant_matvec_defines.svh"
module rvqdm_ctrl
  import rvqdm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [1:0] opcode_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ELEM, S_CBRD, S_CBADD, S_CBWAIT, S_SCALE, S_SCWAIT,
    S_ACTRD, S_MUL, S_MULWAIT, S_ADD, S_ACCWAIT, S_EMIT
  } state_e;

  state_e     state_q;
  logic [3:0] e_q;
  logic [1:0] st_q;
  logic [2:0] c_q;

  // Hold state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      e_q <= 4'd0;
      st_q <= 2'd0;
      c_q <= 3'd0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          e_q <= 4'd0;
          if (accept_i && (opcode_i == OP_GROUP)) state_q <= S_ELEM;
        end
        S_ELEM: begin
          c_q <= 3'd0;
          st_q <= 2'd0;
          if (e_q >= stat_i.g) state_q <= stat_i.row_end ? S_EMIT : S_IDLE;
          else if (!stat_i.pos_ok) e_q <= e_q + 4'd1;
          else state_q <= (stat_i.s == 2'd0) ? S_SCALE : S_CBRD;
        end
        S_CBRD:  state_q <= S_CBADD;
        S_CBADD: state_q <= S_CBWAIT;
        S_CBWAIT: begin
          if (stat_i.fp_done) begin
            if (({1'b0, st_q} + 3'd1) < {1'b0, stat_i.s}) begin
              st_q <= st_q + 2'd1;
              state_q <= S_CBRD;
            end else begin
              state_q <= S_SCALE;
            end
          end
        end
        S_SCALE: state_q <= S_SCWAIT;
        S_SCWAIT: if (stat_i.fp_done) state_q <= S_ACTRD;
        S_ACTRD: begin
          if (c_q >= stat_i.n) begin
            e_q <= e_q + 4'd1;
            state_q <= S_ELEM;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_MULWAIT;
        S_MULWAIT: if (stat_i.fp_done) state_q <= S_ADD;
        S_ADD: state_q <= S_ACCWAIT;
        S_ACCWAIT: begin
          if (stat_i.fp_done) begin
            c_q <= c_q + 3'd1;
            state_q <= S_ACTRD;
          end
        end
        S_EMIT: begin
          if ((c_q + 3'd1) >= stat_i.n) state_q <= S_IDLE;
          else c_q <= c_q + 3'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Decode commands for the datapath
  always_comb begin
    cmd_o = '0;
    cmd_o.fop = FOP_NONE;
    cmd_o.st = st_q;
    cmd_o.e = e_q[2:0];
    cmd_o.col = c_q[1:0];
    unique case (state_q)
      S_ELEM:  cmd_o.w_clr = (e_q < stat_i.g) && stat_i.pos_ok;
      S_CBRD:  cmd_o.cb_rd = 1'b1;
      S_CBADD: cmd_o.fop = FOP_WADD;
      S_SCALE: cmd_o.fop = FOP_SCALE;
      S_ACTRD: cmd_o.act_rd = (c_q < stat_i.n);
      S_MUL:   cmd_o.fop = FOP_MUL;
      S_ADD:   cmd_o.fop = FOP_ACC;
      S_EMIT: begin
        cmd_o.emit = (c_q < stat_i.n);
        cmd_o.last = ((c_q + 3'd1) == stat_i.n);
        cmd_o.sum_clr = ((c_q + 3'd1) >= stat_i.n);
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `RVQDM_ASSERT_IMP(a_done_in_wait, stat_i.fp_done, (state_q == S_CBWAIT || state_q == S_SCWAIT || state_q == S_MULWAIT || state_q == S_ACCWAIT))
  `RVQDM_ASSERT_IMP(a_emit_in_range, cmd_o.emit, c_q < stat_i.n)
  `RVQDM_ASSERT_NXT(a_group_starts, accept_i && opcode_i == OP_GROUP, state_q == S_ELEM)
  `RVQDM_ASSERT(a_no_accept_busy, !(accept_i && busy_o))

endmodule

FILE: rtl/rvq_dequant_matvec.sv
// Load beats write a codebook word or an activation into its store. A group
// beat steps through its elements, stages and columns, then emits results on a row end;
// every float step goes through the one shared two-stage fp32 add/multiply unit.
// Results appear one per cycle, each marked by strobe_o for one cycle.
// Reset sets config defaults, clears column sums, strobe and control; stores stay unset.
module rvq_dequant_matvec
  import rvqdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  stage_i,
  input  logic [9:0]  index_i,
  input  logic [2:0]  sub_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  code0_i,
  input  logic [7:0]  code1_i,
  input  logic [7:0]  code2_i,
  input  logic [15:0] scale_i,
  input  logic [11:0] row_i,
  input  logic        row_end_i,
  output logic        strobe_o,
  output logic [11:0] out_row_o,
  output logic [1:0]  out_column_o,
  output logic [31:0] sum_value_o,
  output logic        last_o
);

  logic     accept;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign accept = start && !busy;

  rvqdm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  rvqdm_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .stage_i      (stage_i),
    .index_i      (index_i),
    .sub_i        (sub_i),
    .value_i      (value_i),
    .code0_i      (code0_i),
    .code1_i      (code1_i),
    .code2_i      (code2_i),
    .scale_i      (scale_i),
    .row_i        (row_i),
    .row_end_i    (row_end_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .strobe_o     (strobe_o),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .sum_value_o  (sum_value_o),
    .last_o       (last_o)
  );

endmodule
